### design/atlc_pkg.sv
// Shared types and constants for the antenna tuner L/C search.
// No dependencies.
package atlc_pkg;

    localparam int IND_BITS_DEF = 7;
    localparam int CAP_BITS_DEF = 8;
    localparam logic [15:0] SWR_START = 16'd25574;
    localparam logic [15:0] SWR_SAT = 16'hFFFF;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_COARSE_L = 3'd1;
    localparam logic [2:0] PH_COARSE_C = 3'd2;
    localparam logic [2:0] PH_FINE = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_SIDE_C = 3'd5;

    localparam logic [2:0] REG_MAX_SWR = 3'd0;
    localparam logic [2:0] REG_IND_RISE = 3'd1;
    localparam logic [2:0] REG_CAP_RISE = 3'd2;
    localparam logic [2:0] REG_IND_STEP = 3'd3;
    localparam logic [2:0] REG_CAP_STEP = 3'd4;
    localparam logic [2:0] REG_FINE_ROUNDS = 3'd5;
    localparam logic [2:0] REG_SILENCE = 3'd6;

    // Classified sample from the front part: silence, saturation or a ratio to divide.
    typedef struct packed {
        logic        silent;
        logic        sat;
        logic [13:0] num;
        logic [12:0] den;
    } atlc_sample_t;

endpackage

### design/atlc_front.sv
// Front part: accepts power samples and classifies them for the SWR divider.
// Depends on atlc_pkg.
module atlc_front
    import atlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [11:0]  reflected_sum,
    input  logic [11:0]  forward_sum,
    input  logic [11:0]  silence_level,
    output logic         q_valid,
    input  logic         q_ready,
    output atlc_sample_t q_data
);
    // Two-entry queue toward the back part.
    atlc_sample_t mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    atlc_sample_t cls;
    logic [12:0]  r, f;

    always_comb
    begin
        r = {1'b0, reflected_sum} + 13'd1;
        f = {1'b0, forward_sum} + 13'd1;
        cls.silent = (r < {1'b0, silence_level}) && (f < {1'b0, silence_level});
        cls.sat    = (f <= r);
        cls.num    = {1'b0, f} + {1'b0, r};
        cls.den    = f - r;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
        end
    end
endmodule

### design/atlc_back.sv
// Back part: serial SWR divider and the L/C search sequencer with output register.
// Depends on atlc_pkg.
module atlc_back
    import atlc_pkg::*;
#(
    parameter int IND_BITS = IND_BITS_DEF,
    parameter int CAP_BITS = CAP_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  atlc_sample_t        q_data,
    input  logic [15:0]         max_swr,
    input  logic [15:0]         ind_rise_limit,
    input  logic [15:0]         cap_rise_limit,
    input  logic [6:0]          ind_sweep_step,
    input  logic [7:0]          cap_sweep_step,
    input  logic [4:0]          fine_rounds,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IND_BITS-1:0] o_ind,
    output logic [CAP_BITS-1:0] o_cap,
    output logic                o_side,
    output logic [15:0]         o_swr,
    output logic [2:0]          o_phase,
    output logic                o_tuned,
    output logic                o_done
);
    localparam int IW = IND_BITS + 2;   // signed room for code +/- offset
    localparam int CW = CAP_BITS + 2;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_SEEK = 3'd3;
    localparam logic [2:0] ST_CONT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  st_reg, st_next;
    // Restoring divider: quotient of num*256/den, 22 bits, one bit per cycle.
    logic [21:0] quo_reg, quo_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] den_reg, den_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [15:0] swr_reg, swr_next;

    logic [2:0]          phase_reg, phase_next;
    logic [IND_BITS-1:0] ind_reg, ind_next, bind_reg, bind_next, cind_reg, cind_next;
    logic [CAP_BITS-1:0] cap_reg, cap_next, bcap_reg, bcap_next, ccap_reg, ccap_next;
    logic                side_reg, side_next, tuned_reg, tuned_next, done_reg, done_next;
    logic [15:0]         best_reg, best_next;
    logic signed [2:0]   io_reg, io_next, co_reg, co_next;
    logic [1:0]          fss_reg, fss_next;
    logic [4:0]          rc_reg, rc_next;
    logic                ov_reg, ov_next;

    logic [13:0] trial;
    logic [7:0]  ist, cst;
    logic [IND_BITS:0] inx;
    logic [CAP_BITS:0] cnx;
    logic signed [3:0] s4, co_w, io_w;
    logic signed [IW-1:0] ni;
    logic signed [CW-1:0] nc;

    assign q_ready   = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign o_ind = ind_reg;
    assign o_cap = cap_reg;
    assign o_side = side_reg;
    assign o_swr = swr_reg;
    assign o_phase = phase_reg;
    assign o_tuned = tuned_reg;
    assign o_done = done_reg;

    always_comb
    begin
        st_next = st_reg; quo_next = quo_reg; rem_next = rem_reg; den_next = den_reg;
        dcnt_next = dcnt_reg; swr_next = swr_reg;
        phase_next = phase_reg; ind_next = ind_reg; cap_next = cap_reg;
        bind_next = bind_reg; bcap_next = bcap_reg; cind_next = cind_reg;
        ccap_next = ccap_reg; side_next = side_reg; tuned_next = tuned_reg;
        done_next = done_reg; best_next = best_reg; io_next = io_reg; co_next = co_reg;
        fss_next = fss_reg; rc_next = rc_reg; ov_next = ov_reg;
        ist = (ind_sweep_step == 7'd0) ? 8'd1 : {1'b0, ind_sweep_step};
        cst = (cap_sweep_step == 8'd0) ? 8'd1 : cap_sweep_step;
        trial = {rem_reg, quo_reg[21]};
        inx = '0; cnx = '0;
        s4 = signed'({2'b00, fss_reg});
        co_w = 4'sd0; io_w = 4'sd0; ni = '0; nc = '0;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    if (q_data.silent)
                    begin
                        swr_next = 16'd0; st_next = ST_STEP;
                    end
                    else if (q_data.sat)
                    begin
                        swr_next = SWR_SAT; st_next = ST_STEP;
                    end
                    else
                    begin
                        quo_next = {q_data.num, 8'd0};
                        rem_next = '0;
                        den_next = q_data.den;
                        dcnt_next = 5'd21;
                        st_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // remainder stays below den, so 14-bit trial suffices
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 13'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[20:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[12:0];
                    quo_next = {quo_reg[20:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0)
                begin
                    swr_next = (quo_next[21:16] != 6'd0) ? SWR_SAT : quo_next[15:0];
                    st_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                done_next = 1'b0;
                st_next = ST_OUT;
                case (phase_reg)
                    PH_COARSE_L:
                    begin
                        if (swr_reg == 16'd0)
                        begin
                            ind_next = bind_reg; phase_next = PH_COARSE_C;
                            st_next = ST_SEEK; dcnt_next = 5'd1;
                        end
                        else
                        begin
                            best_next = best_reg;
                            bind_next = bind_reg;
                            if (swr_reg < best_reg)
                            begin
                                best_next = swr_reg; bind_next = ind_reg;
                            end
                            if (16'(swr_reg - best_next) > ind_rise_limit)
                            begin
                                ind_next = bind_next; phase_next = PH_COARSE_C;
                                st_next = ST_SEEK; dcnt_next = 5'd1;
                            end
                            else
                            begin
                                inx = {1'b0, ind_reg} + (IND_BITS+1)'(ist);
                                if (ist >= 8'(1 << IND_BITS) && IND_BITS < 8)
                                    inx[IND_BITS] = 1'b1;
                                if (!inx[IND_BITS])
                                    ind_next = inx[IND_BITS-1:0];
                                else
                                begin
                                    ind_next = bind_next; phase_next = PH_COARSE_C;
                                    st_next = ST_SEEK; dcnt_next = 5'd1;
                                end
                            end
                        end
                    end
                    PH_COARSE_C, PH_SIDE_C:
                    begin
                        if (swr_reg == 16'd0)
                        begin
                            st_next = ST_SEEK; dcnt_next = 5'd2;
                        end
                        else
                        begin
                            best_next = best_reg; bcap_next = bcap_reg;
                            if (swr_reg < best_reg)
                            begin
                                best_next = swr_reg; bcap_next = cap_reg;
                            end
                            cnx = {1'b0, cap_reg} + (CAP_BITS+1)'(cst);
                            if ((cst >= 8'(1 << CAP_BITS) && CAP_BITS < 8) ||
                                16'(swr_reg - best_next) > cap_rise_limit || cnx[CAP_BITS])
                            begin
                                st_next = ST_SEEK; dcnt_next = 5'd2;
                            end
                            else
                                cap_next = cnx[CAP_BITS-1:0];
                        end
                    end
                    PH_FINE:
                    begin
                        if (swr_reg < max_swr)
                        begin
                            tuned_next = 1'b1; phase_next = PH_CHECK;
                        end
                        else
                        begin
                            if (swr_reg == 16'd0)
                            begin
                                io_next = 3'(io_reg + 3'(s4)); co_next = -3'(s4);
                            end
                            else
                            begin
                                if (swr_reg < best_reg)
                                begin
                                    best_next = swr_reg; bind_next = ind_reg;
                                    bcap_next = cap_reg;
                                end
                                co_next = 3'(co_reg + 3'(s4));
                            end
                            st_next = ST_SEEK; dcnt_next = 5'd3;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (swr_reg > max_swr)
                        begin
                            side_next = 1'b1; phase_next = PH_SIDE_C;
                            best_next = SWR_START; bcap_next = cap_reg;
                            if (cst < 8'(1 << CAP_BITS) || CAP_BITS >= 8)
                                cap_next = CAP_BITS'(cst);
                            else
                            begin
                                st_next = ST_SEEK; dcnt_next = 5'd2;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IDLE; done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (swr_reg > max_swr)
                        begin
                            tuned_next = 1'b0; side_next = 1'b0;
                            cap_next = '0; best_next = SWR_START; bind_next = '0;
                            if (ist < 8'(1 << IND_BITS) || IND_BITS >= 8)
                            begin
                                ind_next = IND_BITS'(ist); phase_next = PH_COARSE_L;
                            end
                            else
                            begin
                                ind_next = '0; phase_next = PH_COARSE_C;
                                st_next = ST_SEEK; dcnt_next = 5'd1;
                            end
                        end
                    end
                endcase
            end
            ST_SEEK:
            begin
                // dcnt: 1 = start cap sweep, 2 = end cap sweep, 3 = fine seek step
                case (dcnt_reg)
                    5'd1:
                    begin
                        best_next = SWR_START; bcap_next = cap_reg;
                        if (cst < 8'(1 << CAP_BITS) || CAP_BITS >= 8)
                        begin
                            cap_next = CAP_BITS'(cst); st_next = ST_OUT;
                        end
                        else
                            dcnt_next = 5'd2;
                    end
                    5'd2:
                    begin
                        cap_next = bcap_reg;
                        if (phase_reg == PH_COARSE_C)
                        begin
                            fss_next = 2'd3; rc_next = '0; st_next = ST_CONT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE; done_next = 1'b1; st_next = ST_OUT;
                        end
                    end
                    default:
                    begin
                        // one candidate offset per cycle
                        co_w = 4'(co_reg); io_w = 4'(io_reg);
                        if (co_w >= 4'sd2)
                        begin
                            co_w = -s4; io_w = io_w + s4;
                        end
                        if (io_w >= 4'sd2)
                        begin
                            ind_next = bind_reg; cap_next = bcap_reg;
                            rc_next = rc_reg + 5'd1; st_next = ST_CONT;
                        end
                        else
                        begin
                            ni = signed'(IW'(cind_reg)) + IW'(io_w);
                            nc = signed'(CW'(ccap_reg)) + CW'(co_w);
                            if (ni >= 0 && ni < IW'(1 << IND_BITS) &&
                                nc >= 0 && nc < CW'(1 << CAP_BITS))
                            begin
                                ind_next = ni[IND_BITS-1:0]; cap_next = nc[CAP_BITS-1:0];
                                io_next = 3'(io_w); co_next = 3'(co_w);
                                st_next = ST_OUT;
                            end
                            else
                            begin
                                io_next = 3'(io_w); co_next = 3'(co_w + s4);
                            end
                        end
                    end
                endcase
            end
            ST_CONT:
            begin
                if (fss_reg == 2'd0)
                begin
                    phase_next = PH_CHECK; st_next = ST_OUT;
                end
                else if (rc_reg < fine_rounds)
                begin
                    cind_next = ind_reg; ccap_next = cap_reg;
                    best_next = SWR_START; bind_next = ind_reg; bcap_next = cap_reg;
                    phase_next = PH_FINE;
                    io_next = -3'(s4); co_next = -3'(s4);
                    st_next = ST_SEEK; dcnt_next = 5'd3;
                end
                else
                begin
                    fss_next = fss_reg - 2'd1; rc_next = '0;
                end
            end
            ST_OUT:
            begin
                ov_next = 1'b1; st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next; rem_reg <= rem_next; den_reg <= den_next;
        swr_reg <= swr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; dcnt_reg <= '0; phase_reg <= PH_IDLE;
            ind_reg <= '0; cap_reg <= '0; bind_reg <= '0; bcap_reg <= '0;
            cind_reg <= '0; ccap_reg <= '0; side_reg <= 1'b0; tuned_reg <= 1'b0;
            done_reg <= 1'b0; best_reg <= '0; io_reg <= '0; co_reg <= '0;
            fss_reg <= 2'd3; rc_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; dcnt_reg <= dcnt_next; phase_reg <= phase_next;
            ind_reg <= ind_next; cap_reg <= cap_next; bind_reg <= bind_next;
            bcap_reg <= bcap_next; cind_reg <= cind_next; ccap_reg <= ccap_next;
            side_reg <= side_next; tuned_reg <= tuned_next; done_reg <= done_next;
            best_reg <= best_next; io_reg <= io_next; co_reg <= co_next;
            fss_reg <= fss_next; rc_reg <= rc_next; ov_reg <= ov_next;
        end
    end
endmodule

### design/antenna_tuner_lc_search.sv
// Top level of the antenna tuner L/C search: config registers, front and back parts.
// Depends on atlc_pkg, atlc_front, atlc_back.
//
// channel   | dir | beat contents (low bit first)
// s_axis    | in  | reflected_sum[11:0], forward_sum[11:0]
// m_axis    | out | ind_code, cap_code, cap_antenna_side, swr_value, search_phase,
//           |     | is_tuned, search_done
// cfg       | in  | cfg_we, cfg_index, cfg_wdata
//
// A divided beat goes from accept to accept through divider load, the divider iterations,
// one search step, output load and the output handshake. Silence and saturation
// skip the divider. Sweep ends and fine moves add seek steps, skipped out-of-range
// neighbor steps and round bookkeeping steps.
// A two-entry queue decouples the input; a stalled result holds the back part.
// Reset returns the search state to idle and loads register defaults; the divider and SWR registers are not reset.
module antenna_tuner_lc_search
    import atlc_pkg::*;
#(
    parameter int IND_BITS = IND_BITS_DEF,
    parameter int CAP_BITS = CAP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // reflected_sum[11:0], forward_sum[23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ind_code, cap_code, cap_antenna_side, swr_value, search_phase, is_tuned, search_done
    output logic [((IND_BITS+CAP_BITS+22+7)/8)*8-1:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int OW = IND_BITS + CAP_BITS + 22;
    localparam int OB = ((OW + 7) / 8) * 8;

    logic [15:0] max_swr_reg, ind_rise_reg, cap_rise_reg;
    logic [6:0]  ind_step_reg;
    logic [7:0]  cap_step_reg;
    logic [4:0]  rounds_reg;
    logic [11:0] silence_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_swr_reg <= 16'd2893; ind_rise_reg <= 16'd2048; cap_rise_reg <= 16'd1024;
            ind_step_reg <= 7'd3; cap_step_reg <= 8'd3; rounds_reg <= 5'd16;
            silence_reg <= 12'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_SWR:     max_swr_reg  <= cfg_wdata;
                REG_IND_RISE:    ind_rise_reg <= cfg_wdata;
                REG_CAP_RISE:    cap_rise_reg <= cfg_wdata;
                REG_IND_STEP:    ind_step_reg <= cfg_wdata[6:0];
                REG_CAP_STEP:    cap_step_reg <= cfg_wdata[7:0];
                REG_FINE_ROUNDS: rounds_reg   <= cfg_wdata[4:0];
                REG_SILENCE:     silence_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    logic         q_valid, q_ready;
    atlc_sample_t q_data;
    logic [IND_BITS-1:0] o_ind;
    logic [CAP_BITS-1:0] o_cap;
    logic        o_side, o_tuned, o_done;
    logic [15:0] o_swr;
    logic [2:0]  o_phase;

    atlc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .reflected_sum(s_axis_tdata[11:0]), .forward_sum(s_axis_tdata[23:12]),
        .silence_level(silence_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    atlc_back #(.IND_BITS(IND_BITS), .CAP_BITS(CAP_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .max_swr(max_swr_reg), .ind_rise_limit(ind_rise_reg),
        .cap_rise_limit(cap_rise_reg), .ind_sweep_step(ind_step_reg),
        .cap_sweep_step(cap_step_reg), .fine_rounds(rounds_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .o_ind(o_ind), .o_cap(o_cap), .o_side(o_side), .o_swr(o_swr),
        .o_phase(o_phase), .o_tuned(o_tuned), .o_done(o_done)
    );

    assign m_axis_tdata = OB'({o_done, o_tuned, o_phase, o_swr, o_side, o_cap, o_ind});

    // a result never shows a phase code beyond side C
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_phase <= PH_SIDE_C)) else $error("bad phase");
    // done only goes with idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_done) |-> (o_phase == PH_IDLE)) else $error("done not idle");
    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("unstable");
endmodule
